// File: rtl/tpp_pkg.sv
package tpp_pkg;

  localparam int TIME_FRAC_BITS_DEF = 20;

  localparam logic [30:0] ONE_PROGRESS = 31'h4000_0000;
  localparam logic [31:0] MAX32        = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    MS_UNCONFIGURED = 3'd0,
    MS_RUNNING      = 3'd1,
    MS_STOPPING     = 3'd2,
    MS_COMPLETE     = 3'd3,
    MS_CANCELED     = 3'd4
  } move_state_t;

  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_CANCEL = 2'd2;

  localparam logic [2:0] REG_RAMP_ACCEL   = 3'd0;
  localparam logic [2:0] REG_RAMP_TIME    = 3'd1;
  localparam logic [2:0] REG_CRUISE_TIME  = 3'd2;
  localparam logic [2:0] REG_TOTAL_TIME   = 3'd3;
  localparam logic [2:0] REG_PEAK_VEL     = 3'd4;

endpackage

// File: rtl/tpp_mul.sv
module tpp_mul (
  input  logic        clk,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [63:0] prod
);

  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= 64'(op_a) * 64'(op_b);
  end

  assign prod = prod_r;

endmodule

// File: rtl/tpp_div.sv
module tpp_div #(
  parameter int DW = 57
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [31:0]   divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] q_r;
  logic [31:0]   rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  // one quotient bit per cycle, restoring form
  assign trial = {rem_r, q_r[DW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= dividend;
        rem_r  <= '0;
        cnt_r  <= CW'(DW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        q_r   <= {q_r[DW-2:0], ge};
        rem_r <= ge ? diff[31:0] : trial[31:0];
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// File: rtl/trapezoid_progress_profile_top.sv
// Trapezoidal progress profile. Load the five registers, then send start, tick and
// cancel beats; each beat returns one result with accepted flag, state, progress
// (Q1.30), velocity (Q8.24/s) and signed acceleration (Q12.20/s^2). One 32x32
// multiplier is shared under a sequencer: start, rejected and no-motion beats use
// no multiply, a tick up to four multiplies, and a cancel waits on the bit-serial
// stop-time divider unless the velocity or the acceleration is zero. in_ready is
// low while a beat is in work; a finished result waits in the output register while
// the next beat is taken, and a result still waiting there holds the next one back.
module trapezoid_progress_profile_top #(
  parameter int TIME_FRAC_BITS = tpp_pkg::TIME_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_tick_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic [2:0]  out_move_state,
  output logic [30:0] out_progress,
  output logic [31:0] out_progress_velocity,
  output logic [32:0] out_progress_accel_out
);

  localparam int SH_VEL  = TIME_FRAC_BITS - 4;
  localparam int SH_HALF = TIME_FRAC_BITS - 5;
  localparam int SH_PROG = TIME_FRAC_BITS - 6;
  localparam int DIV_W   = 33 + SH_VEL;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_TICK, ST_PHASE,
    ST_RA1, ST_RA2, ST_RA3,
    ST_CR1, ST_CR2,
    ST_DE1, ST_DE2, ST_DE3,
    ST_SP1, ST_SP2, ST_SP3, ST_SP4, ST_SP5,
    ST_CA2, ST_CA3, ST_CA4,
    ST_DONE
  } seq_state_t;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (|v[63:32]) ? tpp_pkg::MAX32 : v[31:0];
  endfunction

  function automatic logic [30:0] satp(input logic [63:0] v);
    return (v > 64'(tpp_pkg::ONE_PROGRESS)) ? tpp_pkg::ONE_PROGRESS : v[30:0];
  endfunction

  // configuration
  logic [31:0] accel_cfg_r, ramp_r, cruise_r, total_r, peak_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_cfg_r <= 32'h0010_0000;
      ramp_r      <= '0;
      cruise_r    <= '0;
      total_r     <= '0;
      peak_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        tpp_pkg::REG_RAMP_ACCEL:  accel_cfg_r <= cfg_wdata;
        tpp_pkg::REG_RAMP_TIME:   ramp_r      <= cfg_wdata;
        tpp_pkg::REG_CRUISE_TIME: cruise_r    <= cfg_wdata;
        tpp_pkg::REG_TOTAL_TIME:  total_r     <= cfg_wdata;
        tpp_pkg::REG_PEAK_VEL:    peak_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  seq_state_t          state_r, state_nxt;
  tpp_pkg::move_state_t phase_r, phase_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic [30:0] prog_r, prog_nxt;
  logic [31:0] vel_r, vel_nxt;
  logic [32:0] accel_r, accel_nxt;
  logic [30:0] ssp_r, ssp_nxt;
  logic [31:0] ssv_r, ssv_nxt;
  logic [31:0] stop_time_r, stop_time_nxt;
  logic [30:0] sep_r, sep_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [31:0] dt_r, dt_nxt;
  logic        acc_r, acc_nxt;
  logic [31:0] tmp_r, tmp_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [63:0] gain_r, gain_nxt;
  logic        ov_r, ov_nxt;
  logic        oacc_r, oacc_nxt;
  logic [2:0]  ost_r, ost_nxt;
  logic [30:0] oprog_r, oprog_nxt;
  logic [31:0] ovel_r, ovel_nxt;
  logic [32:0] oaccel_r, oaccel_nxt;

  logic [31:0]      mul_a, mul_b;
  logic [63:0]      prod;
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_dividend, div_q;

  tpp_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod(prod));

  tpp_div #(.DW(DIV_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(accel_cfg_r), .done(div_done), .quotient(div_q)
  );

  logic [31:0] vsat;
  logic [32:0] neg_a;
  logic [31:0] dur;
  logic        stopping;
  logic [63:0] loss;

  assign vsat     = sat32(prod >> SH_VEL);
  assign neg_a    = (~{1'b0, accel_cfg_r}) + 33'd1;
  assign stopping = phase_r == tpp_pkg::MS_STOPPING;
  assign dur      = stopping ? stop_time_r : total_r;
  assign loss     = prod >> SH_HALF;
  assign div_dividend = (DIV_W'(vel_r) << SH_VEL) + DIV_W'(accel_cfg_r) - DIV_W'(1);

  always_comb begin
    case (state_r)
      ST_RA2, ST_DE2, ST_SP3: mul_a = vsat;
      ST_CR1:                 mul_a = peak_r;
      ST_SP1, ST_CA3:         mul_a = ssv_r;
      default:                mul_a = accel_cfg_r;
    endcase
    case (state_r)
      ST_SP4:  mul_b = rem_r;
      ST_CA3:  mul_b = stop_time_r;
      default: mul_b = tmp_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    elapsed_nxt   = elapsed_r;
    prog_nxt      = prog_r;
    vel_nxt       = vel_r;
    accel_nxt     = accel_r;
    ssp_nxt       = ssp_r;
    ssv_nxt       = ssv_r;
    stop_time_nxt = stop_time_r;
    sep_nxt       = sep_r;
    mode_nxt      = mode_r;
    dt_nxt        = dt_r;
    acc_nxt       = acc_r;
    tmp_nxt       = tmp_r;
    rem_nxt       = rem_r;
    gain_nxt      = gain_r;
    ov_nxt        = ov_r;
    oacc_nxt      = oacc_r;
    ost_nxt       = ost_r;
    oprog_nxt     = oprog_r;
    ovel_nxt      = ovel_r;
    oaccel_nxt    = oaccel_r;
    div_start     = 1'b0;

    if (ov_r && out_ready) ov_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          dt_nxt    = in_tick_time;
          acc_nxt   = 1'b0;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_DONE;
        case (mode_r)
          tpp_pkg::MODE_START: begin
            if (phase_r != tpp_pkg::MS_RUNNING && !stopping) begin
              acc_nxt     = 1'b1;
              elapsed_nxt = '0;
              vel_nxt     = '0;
              if (total_r == '0) begin
                phase_nxt = tpp_pkg::MS_COMPLETE;
                prog_nxt  = tpp_pkg::ONE_PROGRESS;
                accel_nxt = '0;
              end else begin
                phase_nxt = tpp_pkg::MS_RUNNING;
                prog_nxt  = '0;
                accel_nxt = {1'b0, accel_cfg_r};
              end
            end
          end
          tpp_pkg::MODE_TICK: begin
            if (dt_r != '0 && phase_r != tpp_pkg::MS_UNCONFIGURED) begin
              acc_nxt = 1'b1;
              if (phase_r == tpp_pkg::MS_RUNNING || stopping) state_nxt = ST_TICK;
            end
          end
          tpp_pkg::MODE_CANCEL: begin
            if (phase_r == tpp_pkg::MS_RUNNING) begin
              acc_nxt     = 1'b1;
              ssp_nxt     = prog_r;
              ssv_nxt     = vel_r;
              elapsed_nxt = '0;
              if (vel_r == '0) begin
                stop_time_nxt = '0;
                state_nxt     = ST_CA3;
              end else if (accel_cfg_r == '0) begin
                stop_time_nxt = tpp_pkg::MAX32;
                state_nxt     = ST_CA3;
              end else begin
                div_start = 1'b1;
                state_nxt = ST_CA2;
              end
            end
          end
          default: ;
        endcase
      end
      ST_TICK: begin
        // clamp at the phase duration
        if (elapsed_r >= dur || dt_r >= dur - elapsed_r) elapsed_nxt = dur;
        else elapsed_nxt = elapsed_r + dt_r;
        state_nxt = ST_PHASE;
      end
      ST_PHASE: begin
        if (elapsed_r >= dur) begin
          vel_nxt   = '0;
          accel_nxt = '0;
          state_nxt = ST_DONE;
          if (stopping) begin
            prog_nxt  = sep_r;
            phase_nxt = tpp_pkg::MS_CANCELED;
          end else begin
            prog_nxt  = tpp_pkg::ONE_PROGRESS;
            phase_nxt = tpp_pkg::MS_COMPLETE;
          end
        end else if (stopping) begin
          tmp_nxt   = elapsed_r;
          rem_nxt   = dur - elapsed_r;
          state_nxt = ST_SP1;
        end else if (elapsed_r < ramp_r) begin
          tmp_nxt   = elapsed_r;
          state_nxt = ST_RA1;
        end else if ({1'b0, elapsed_r} < {1'b0, ramp_r} + {1'b0, cruise_r}) begin
          tmp_nxt   = elapsed_r - (ramp_r >> 1);
          state_nxt = ST_CR1;
        end else begin
          tmp_nxt   = dur - elapsed_r;
          state_nxt = ST_DE1;
        end
      end
      ST_RA1: state_nxt = ST_RA2;
      ST_RA2: begin
        vel_nxt   = vsat;
        state_nxt = ST_RA3;
      end
      ST_RA3: begin
        prog_nxt  = satp(prod >> SH_HALF);
        accel_nxt = {1'b0, accel_cfg_r};
        state_nxt = ST_DONE;
      end
      ST_CR1: state_nxt = ST_CR2;
      ST_CR2: begin
        vel_nxt   = peak_r;
        prog_nxt  = satp(prod >> SH_PROG);
        accel_nxt = '0;
        state_nxt = ST_DONE;
      end
      ST_DE1: state_nxt = ST_DE2;
      ST_DE2: begin
        vel_nxt   = vsat;
        state_nxt = ST_DE3;
      end
      ST_DE3: begin
        prog_nxt  = tpp_pkg::ONE_PROGRESS - satp(prod >> SH_HALF);
        accel_nxt = neg_a;
        state_nxt = ST_DONE;
      end
      ST_SP1: state_nxt = ST_SP2;
      ST_SP2: begin
        gain_nxt  = 64'(ssp_r) + (prod >> SH_PROG);
        state_nxt = ST_SP3;
      end
      ST_SP3: state_nxt = ST_SP4;
      ST_SP4: begin
        prog_nxt  = satp((gain_r > loss) ? gain_r - loss : 64'd0);
        state_nxt = ST_SP5;
      end
      ST_SP5: begin
        vel_nxt   = vsat;
        accel_nxt = neg_a;
        state_nxt = ST_DONE;
      end
      ST_CA2: begin
        if (div_done) begin
          stop_time_nxt = (|div_q[DIV_W-1:32]) ? tpp_pkg::MAX32 : div_q[31:0];
          state_nxt     = ST_CA3;
        end
      end
      ST_CA3: state_nxt = ST_CA4;
      ST_CA4: begin
        sep_nxt = satp(64'(ssp_r) + (prod >> SH_HALF));
        if (stop_time_r != '0) begin
          phase_nxt = tpp_pkg::MS_STOPPING;
          accel_nxt = neg_a;
        end else begin
          phase_nxt = tpp_pkg::MS_CANCELED;
          accel_nxt = '0;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!ov_r || out_ready) begin
          ov_nxt     = 1'b1;
          oacc_nxt   = acc_r;
          ost_nxt    = phase_r;
          oprog_nxt  = prog_r;
          ovel_nxt   = vel_r;
          oaccel_nxt = accel_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= tpp_pkg::MS_UNCONFIGURED;
      elapsed_r   <= '0;
      prog_r      <= '0;
      vel_r       <= '0;
      accel_r     <= '0;
      ssp_r       <= '0;
      ssv_r       <= '0;
      stop_time_r <= '0;
      sep_r       <= '0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      elapsed_r   <= elapsed_nxt;
      prog_r      <= prog_nxt;
      vel_r       <= vel_nxt;
      accel_r     <= accel_nxt;
      ssp_r       <= ssp_nxt;
      ssv_r       <= ssv_nxt;
      stop_time_r <= stop_time_nxt;
      sep_r       <= sep_nxt;
      ov_r        <= ov_nxt;
    end
    mode_r   <= mode_nxt;
    dt_r     <= dt_nxt;
    acc_r    <= acc_nxt;
    tmp_r    <= tmp_nxt;
    rem_r    <= rem_nxt;
    gain_r   <= gain_nxt;
    oacc_r   <= oacc_nxt;
    ost_r    <= ost_nxt;
    oprog_r  <= oprog_nxt;
    ovel_r   <= ovel_nxt;
    oaccel_r <= oaccel_nxt;
  end

  assign in_ready               = state_r == ST_IDLE;
  assign out_valid              = ov_r;
  assign out_accepted           = oacc_r;
  assign out_move_state         = ost_r;
  assign out_progress           = oprog_r;
  assign out_progress_velocity  = ovel_r;
  assign out_progress_accel_out = oaccel_r;

endmodule

// File: rtl/tpp_checker.sv
module tpp_props (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_move_state,
  input logic [30:0] out_progress,
  input logic [31:0] out_progress_velocity,
  input logic [32:0] out_progress_accel_out
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_progress)
      && $stable(out_move_state))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_progress <= tpp_pkg::ONE_PROGRESS)
    else $error("progress above one");

  a_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_move_state == tpp_pkg::MS_COMPLETE |->
      out_progress == tpp_pkg::ONE_PROGRESS && out_progress_velocity == '0
      && out_progress_accel_out == '0)
    else $error("complete move not at rest at one");

  a_canceled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_move_state == tpp_pkg::MS_CANCELED |->
      out_progress_velocity == '0 && out_progress_accel_out == '0)
    else $error("canceled move still moving");

endmodule

bind trapezoid_progress_profile_top tpp_props u_tpp_props (.*);
